>>> rtl/sswi_pkg.sv
package sswi_pkg;

    localparam int SEGMENT_COUNT_DEF = 4;

    localparam logic [31:0] CELL_MASK     = 32'hFFC0_0000;
    localparam int          CELL_SHIFT    = 10;
    localparam int          LOCAL_LIMIT   = 32'h0000_7FFF;
    localparam int          FRACTION_BITS = 12;
    localparam int          DIV_STEPS     = FRACTION_BITS + 1;
    localparam logic [12:0] NO_HIT        = 13'h1000;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_CHUNK = 2'd1,
        ACT_WALL  = 2'd2,
        ACT_READ  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_WPRE,
        ST_WSEG,
        ST_DIV,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [1:0]         seg_index;
        logic signed [31:0] point_a_x;
        logic signed [31:0] point_a_y;
        logic signed [31:0] point_b_x;
        logic signed [31:0] point_b_y;
        logic signed [15:0] wall_normal_first;
        logic signed [15:0] wall_normal_second;
    } in_item_t;

    typedef struct packed {
        logic [12:0]        hit_fraction;
        logic signed [15:0] hit_normal_first;
        logic signed [15:0] hit_normal_second;
    } out_item_t;

    // one pass of the shared unit: addend +/- (product or bypass operand)
    typedef struct packed {
        logic [31:0] addend;
        logic [15:0] mul_a;
        logic [15:0] mul_b;
        logic [31:0] bypass;
        logic        use_mul;
        logic        sub;
    } alu_op_t;

endpackage

>>> rtl/sswi_alu.sv
module sswi_alu (
    input  sswi_pkg::alu_op_t op,
    output logic [32:0]       result
);

    logic signed [31:0] prod;
    logic [31:0]        operand;

    always_comb begin
        prod    = $signed(op.mul_a) * $signed(op.mul_b);
        operand = op.use_mul ? prod : op.bypass;
        // bit 32 set on subtract means no borrow
        result  = {1'b0, op.addend} + {1'b0, (op.sub ? ~operand : operand)} + 33'(op.sub);
    end

endmodule

>>> rtl/sweep_segment_wall_intersect.sv
// Load: stores an in-range segment, no result. Read: result valid the cycle after the beat is taken.
// Chunk: per segment, 4 subtracts and a write-back on the shared adder.
// Wall: a setup pass, then per segment 5 to 11 multiply-accumulate steps and, if
// span and side checks pass, 13 divide steps and 1 update on the multiplier/adder.
// One item at a time; s_ready is low while an item is in progress.
// aresetn (synchronous, active low) clears all segments: points zero, fraction 4096.
module sweep_segment_wall_intersect #(
    parameter int SEGMENT_COUNT = sswi_pkg::SEGMENT_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sswi_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sswi_pkg::out_item_t m_data
);

    localparam int IDX_W = (SEGMENT_COUNT > 1) ? $clog2(SEGMENT_COUNT) : 1;
    localparam int V_W   = 32 - sswi_pkg::CELL_SHIFT;

    sswi_pkg::state_t    state_reg, state_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [3:0]          step_reg, step_next;
    sswi_pkg::in_item_t  item_reg;
    logic [15:0]         wx_reg, wy_reg;

    logic [31:0] gsx_reg [SEGMENT_COUNT];
    logic [31:0] gsy_reg [SEGMENT_COUNT];
    logic [31:0] gex_reg [SEGMENT_COUNT];
    logic [31:0] gey_reg [SEGMENT_COUNT];
    logic [15:0] lp_reg  [SEGMENT_COUNT][4];
    logic [15:0] nrm_reg [SEGMENT_COUNT][2];
    logic [12:0] bf_reg  [SEGMENT_COUNT];
    logic [15:0] bnf_reg [SEGMENT_COUNT];
    logic [15:0] bns_reg [SEGMENT_COUNT];

    logic [31:0] nws_reg, nws_next;
    logic [31:0] s_reg, s_next;
    logic [31:0] e_reg, e_next;
    logic [31:0] span_reg, span_next;
    logic [31:0] sw_reg, sw_next;
    logic [31:0] ta_reg, ta_next;
    logic [31:0] tb_reg, tb_next;
    logic [31:0] rem_reg, rem_next;
    logic [12:0] quo_reg, quo_next;
    logic [15:0] ltmp_reg [4];
    logic [15:0] ltmp_next [4];
    logic        out_reg, out_next;

    logic                m_valid_reg, m_valid_next;
    sswi_pkg::out_item_t m_data_reg, m_data_next;

    sswi_pkg::alu_op_t   op;
    logic [32:0]         res;

    logic                accept, in_range, last_seg, fail_span, fail_side, outside;
    logic [IDX_W-1:0]    wi, ri;
    logic [31:0]         base_x, base_z, gsel;
    logic signed [V_W-1:0] v;
    logic [15:0]         wax, way, wbx, wby, p0, p1, p2, p3, nx, ny, dx, dy;
    logic                ld_we, chunk_we, upd_we;

    sswi_alu u_alu (
        .op     (op),
        .result (res)
    );

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == sswi_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign in_range = (int'(s_data.seg_index) < SEGMENT_COUNT);
    assign wi       = IDX_W'(s_data.seg_index);
    assign ri       = (state_reg == sswi_pkg::ST_IDLE) ? wi : cnt_reg;
    assign last_seg = (cnt_reg == IDX_W'(SEGMENT_COUNT - 1));

    assign wax = item_reg.point_a_x[15:0];
    assign way = item_reg.point_a_y[15:0];
    assign wbx = item_reg.point_b_x[15:0];
    assign wby = item_reg.point_b_y[15:0];
    assign p0  = lp_reg[cnt_reg][0];
    assign p1  = lp_reg[cnt_reg][1];
    assign p2  = lp_reg[cnt_reg][2];
    assign p3  = lp_reg[cnt_reg][3];
    assign nx  = nrm_reg[cnt_reg][0];
    assign ny  = nrm_reg[cnt_reg][1];

    assign base_x = item_reg.point_a_x & sswi_pkg::CELL_MASK;
    assign base_z = item_reg.point_a_y & sswi_pkg::CELL_MASK;
    assign v      = res[31:sswi_pkg::CELL_SHIFT];
    assign outside = (v > V_W'(sswi_pkg::LOCAL_LIMIT)) || (v < -V_W'(sswi_pkg::LOCAL_LIMIT));
    assign dx     = ltmp_reg[2] - ltmp_reg[0];
    assign dy     = ltmp_reg[3] - ltmp_reg[1];

    assign fail_span = !(s_reg[31] ^ e_reg[31]) || s_reg[31] || res[31];
    assign fail_side = !(ta_reg[31] ^ res[31]) || (span_reg == 32'd0);

    always_comb begin
        case (step_reg[1:0])
            2'd0:    gsel = gsx_reg[cnt_reg];
            2'd1:    gsel = gsy_reg[cnt_reg];
            2'd2:    gsel = gex_reg[cnt_reg];
            default: gsel = gey_reg[cnt_reg];
        endcase
    end

    // shared unit operand selection
    always_comb begin
        op = '0;
        case (state_reg)
            sswi_pkg::ST_CHUNK: begin
                op.addend = gsel;
                op.bypass = step_reg[0] ? base_z : base_x;
                op.sub    = 1'b1;
            end
            sswi_pkg::ST_WPRE: begin
                op.use_mul = 1'b1;
                op.sub     = 1'b1;
                op.addend  = (step_reg == 4'd0) ? 32'd0 : nws_reg;
                op.mul_a   = (step_reg == 4'd0) ? wax : way;
                op.mul_b   = (step_reg == 4'd0) ? wx_reg : wy_reg;
            end
            sswi_pkg::ST_WSEG: begin
                op.use_mul = 1'b1;
                case (step_reg)
                    4'd0: begin op.addend = nws_reg; op.mul_a = p0; op.mul_b = wx_reg; end
                    4'd1: begin op.addend = s_reg;   op.mul_a = p1; op.mul_b = wy_reg; end
                    4'd2: begin op.addend = nws_reg; op.mul_a = p2; op.mul_b = wx_reg; end
                    4'd3: begin op.addend = e_reg;   op.mul_a = p3; op.mul_b = wy_reg; end
                    4'd4: begin
                        op.addend  = s_reg;
                        op.bypass  = e_reg;
                        op.use_mul = 1'b0;
                        op.sub     = 1'b1;
                    end
                    4'd5: begin op.addend = 32'd0;  op.mul_a = p2;  op.mul_b = nx; op.sub = 1'b1; end
                    4'd6: begin op.addend = sw_reg; op.mul_a = p3;  op.mul_b = ny; op.sub = 1'b1; end
                    4'd7: begin op.addend = sw_reg; op.mul_a = wax; op.mul_b = nx; end
                    4'd8: begin op.addend = ta_reg; op.mul_a = way; op.mul_b = ny; end
                    4'd9: begin op.addend = sw_reg; op.mul_a = wbx; op.mul_b = nx; end
                    default: begin op.addend = tb_reg; op.mul_a = wby; op.mul_b = ny; end
                endcase
            end
            sswi_pkg::ST_DIV: begin
                op.addend = (step_reg == 4'd0) ? s_reg : {rem_reg[30:0], 1'b0};
                op.bypass = span_reg;
                op.sub    = 1'b1;
            end
            default: op = '0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        case (state_reg)
            sswi_pkg::ST_IDLE: begin
                if (accept) begin
                    cnt_next  = '0;
                    step_next = '0;
                    case (sswi_pkg::action_t'(s_data.action))
                        sswi_pkg::ACT_CHUNK: state_next = sswi_pkg::ST_CHUNK;
                        sswi_pkg::ACT_WALL:  state_next = sswi_pkg::ST_WPRE;
                        sswi_pkg::ACT_READ:  state_next = sswi_pkg::ST_OUT;
                        default:             state_next = sswi_pkg::ST_IDLE;
                    endcase
                end
            end
            sswi_pkg::ST_CHUNK: begin
                if (step_reg == 4'd4) begin
                    step_next = '0;
                    if (last_seg) begin
                        state_next = sswi_pkg::ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            sswi_pkg::ST_WPRE: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'd1) begin
                    step_next  = '0;
                    state_next = sswi_pkg::ST_WSEG;
                end
            end
            sswi_pkg::ST_WSEG: begin
                step_next = step_reg + 1'b1;
                if ((step_reg == 4'd4 && fail_span) || (step_reg == 4'd10 && fail_side)) begin
                    step_next = '0;
                    if (last_seg) begin
                        state_next = sswi_pkg::ST_IDLE;
                    end else begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end else if (step_reg == 4'd10) begin
                    step_next  = '0;
                    state_next = sswi_pkg::ST_DIV;
                end
            end
            sswi_pkg::ST_DIV: begin
                step_next = step_reg + 1'b1;
                if (step_reg == 4'(sswi_pkg::DIV_STEPS - 1)) begin
                    step_next  = '0;
                    state_next = sswi_pkg::ST_UPD;
                end
            end
            sswi_pkg::ST_UPD: begin
                step_next = '0;
                if (last_seg) begin
                    state_next = sswi_pkg::ST_IDLE;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = sswi_pkg::ST_WSEG;
                end
            end
            sswi_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = sswi_pkg::ST_IDLE;
                end
            end
            default: state_next = sswi_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        nws_next     = nws_reg;
        s_next       = s_reg;
        e_next       = e_reg;
        span_next    = span_reg;
        sw_next      = sw_reg;
        ta_next      = ta_reg;
        tb_next      = tb_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        ltmp_next    = ltmp_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ld_we        = 1'b0;
        chunk_we     = 1'b0;
        upd_we       = 1'b0;
        case (state_reg)
            sswi_pkg::ST_IDLE: begin
                if (accept) begin
                    ld_we = (s_data.action == sswi_pkg::ACT_LOAD) && in_range;
                    if (s_data.action == sswi_pkg::ACT_READ) begin
                        m_valid_next = 1'b1;
                        if (in_range) begin
                            m_data_next.hit_fraction      = bf_reg[ri];
                            m_data_next.hit_normal_first  = bnf_reg[ri];
                            m_data_next.hit_normal_second = bns_reg[ri];
                        end else begin
                            m_data_next = '{sswi_pkg::NO_HIT, 16'sd0, 16'sd0};
                        end
                    end
                end
            end
            sswi_pkg::ST_CHUNK: begin
                if (step_reg == 4'd4) begin
                    chunk_we = 1'b1;
                end else begin
                    ltmp_next[step_reg[1:0]] = v[15:0];
                    out_next = outside || ((step_reg != 4'd0) && out_reg);
                end
            end
            sswi_pkg::ST_WPRE: nws_next = res[31:0];
            sswi_pkg::ST_WSEG: begin
                case (step_reg)
                    4'd0, 4'd1: s_next    = res[31:0];
                    4'd2, 4'd3: e_next    = res[31:0];
                    4'd4:       span_next = res[31:0];
                    4'd5, 4'd6: sw_next   = res[31:0];
                    4'd7, 4'd8: ta_next   = res[31:0];
                    default:    tb_next   = res[31:0];
                endcase
            end
            sswi_pkg::ST_DIV: begin
                quo_next = {quo_reg[11:0], res[32]};
                rem_next = res[32] ? res[31:0] : op.addend;
            end
            sswi_pkg::ST_UPD: upd_we = (quo_reg < bf_reg[ri]);
            sswi_pkg::ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                end
            end
            default: m_valid_next = m_valid_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sswi_pkg::ST_IDLE;
            cnt_reg     <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < SEGMENT_COUNT; i++) begin
                gsx_reg[i] <= '0;
                gsy_reg[i] <= '0;
                gex_reg[i] <= '0;
                gey_reg[i] <= '0;
                for (int k = 0; k < 4; k++) begin
                    lp_reg[i][k] <= '0;
                end
                nrm_reg[i][0] <= '0;
                nrm_reg[i][1] <= '0;
                bf_reg[i]     <= sswi_pkg::NO_HIT;
                bnf_reg[i]    <= '0;
                bns_reg[i]    <= '0;
            end
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
            if (ld_we) begin
                gsx_reg[wi] <= s_data.point_a_x;
                gsy_reg[wi] <= 32'd0 - s_data.point_a_y;
                gex_reg[wi] <= s_data.point_b_x;
                gey_reg[wi] <= 32'd0 - s_data.point_b_y;
                bf_reg[wi]  <= sswi_pkg::NO_HIT;
            end
            if (chunk_we) begin
                for (int k = 0; k < 4; k++) begin
                    lp_reg[cnt_reg][k] <= ltmp_reg[k];
                end
                nrm_reg[cnt_reg][0] <= out_reg ? 16'd0 : 16'd0 - dy;
                nrm_reg[cnt_reg][1] <= out_reg ? 16'd0 : dx;
            end
            if (upd_we) begin
                bf_reg[cnt_reg]  <= quo_reg;
                bnf_reg[cnt_reg] <= item_reg.wall_normal_second;
                bns_reg[cnt_reg] <= item_reg.wall_normal_first;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
            wx_reg   <= s_data.point_b_y[15:0] - s_data.point_a_y[15:0];
            wy_reg   <= s_data.point_a_x[15:0] - s_data.point_b_x[15:0];
        end
        nws_reg    <= nws_next;
        s_reg      <= s_next;
        e_reg      <= e_next;
        span_reg   <= span_next;
        sw_reg     <= sw_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        ltmp_reg   <= ltmp_next;
        out_reg    <= out_next;
        m_data_reg <= m_data_next;
    end

`ifndef ASSERT_OFF
    a_valid_in_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == sswi_pkg::ST_OUT))
        else $error("result beat outside output state");

    a_frac_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.hit_fraction <= sswi_pkg::NO_HIT))
        else $error("hit fraction above 4096");

    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sswi_pkg::ST_UPD) |-> (quo_reg <= sswi_pkg::NO_HIT))
        else $error("quotient above 4096");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != sswi_pkg::ST_IDLE) |-> (int'(cnt_reg) < SEGMENT_COUNT))
        else $error("segment counter out of range");

    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.action == sswi_pkg::ACT_READ) |=> m_valid_reg)
        else $error("read beat gave no result");
`endif

endmodule
